@@ src/ordered_software_timer_table_core_assert.svh @@
// Assertion macros for the timer table core.
// OSTT_ASSERT is disabled while reset is high; OSTT_ASSERT_NR checks in every cycle.
`ifndef ORDERED_SOFTWARE_TIMER_TABLE_CORE_ASSERT_SVH
`define ORDERED_SOFTWARE_TIMER_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
`define OSTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OSTT_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSTT_ASSERT(lbl, clk, rst, prop, msg)
`define OSTT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ src/ostt_pkg.sv @@
`default_nettype none
package ostt_pkg;

   // field widths
   localparam int TAG_W    = 8;
   localparam int PERIOD_W = 32;
   localparam int DELTA_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int MODE_W   = 2;
   localparam int KIND_W   = 2;
   localparam int POS_W    = 4;

   // request operations
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   // repeat modes; once and the spare code both behave as a single shot
   localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COUNTED = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADDED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

   typedef struct packed {
      logic                operation;
      logic [DELTA_W-1:0]  delta_ms;
      logic [PERIOD_W-1:0] period_ms;
      logic [MODE_W-1:0]   repeat_mode;
      logic [COUNT_W-1:0]  repeat_count;
      logic [TAG_W-1:0]    action_tag;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  fired_tag;
      logic [POS_W-1:0]  position;
      logic              last;
   } rsp_type;

   // one timer entry as held in a cell
   typedef struct packed {
      logic                valid;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] elapsed;
      logic                loops;
      logic [COUNT_W-1:0]  remaining;
      logic [TAG_W-1:0]    tag;
   } entry_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic shift;
      logic compact;
      logic add;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ src/ostt_cell.sv @@
`default_nettype none
module ostt_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  ostt_pkg::cell_ctrl_type ctrl,
   input  ostt_pkg::entry_type     up_entry,
   input  ostt_pkg::entry_type     new_entry,
   input  wire                     hole_below_in,
   output ostt_pkg::entry_type     entry_out,
   output logic                    hole_out,
   output logic                    misplaced
);
   import ostt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      hole_here;

   // a hole at or below this cell pulls the upper neighbour down
   assign hole_here = hole_below_in | ~entry_ff.valid;

   // next entry: rotate, close a hole, or take a new timer as first free cell
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.shift) begin
         entry_in = up_entry;
      end else if (ctrl.compact && hole_here) begin
         entry_in = up_entry;
      end else if (ctrl.add && !entry_ff.valid && !hole_below_in) begin
         entry_in = new_entry;
      end
   end

   // only the valid flag is cleared; timer fields are don't-care until loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
   assign hole_out  = hole_here;
   assign misplaced = entry_ff.valid & hole_below_in;

endmodule
`default_nettype wire

@@ src/ostt_eval.sv @@
`default_nettype none
module ostt_eval (
   input  ostt_pkg::entry_type             head,
   input  wire [ostt_pkg::DELTA_W-1:0]     delta,
   output ostt_pkg::entry_type             result,
   output logic                            fire
);
   import ostt_pkg::*;

   logic [PERIOD_W:0]   sum;
   logic [PERIOD_W-1:0] elapsed_sat;
   logic                due;
   logic                keep;

   // saturating elapsed update and period compare
   assign sum         = {1'b0, head.elapsed} + {{(PERIOD_W - DELTA_W + 1){1'b0}}, delta};
   assign elapsed_sat = sum[PERIOD_W] ? {PERIOD_W{1'b1}} : sum[PERIOD_W-1:0];
   assign due         = elapsed_sat >= head.period;

   // fired timers restart; non-looping ones use up one repeat
   always_comb begin
      result         = head;
      keep           = 1'b1;
      result.elapsed = due ? '0 : elapsed_sat;
      if (due && !head.loops) begin
         if (head.remaining <= COUNT_W'(1)) begin
            result.remaining = '0;
            keep             = 1'b0;
         end else begin
            result.remaining = head.remaining - COUNT_W'(1);
         end
      end
      result.valid = head.valid & keep;
   end

   assign fire = head.valid & due;

endmodule
`default_nettype wire

@@ src/ordered_software_timer_table_core.sv @@
// Ordered timer table. Timers sit in a row of SLOTS cells in the order they
// were added. On an add request the first free cell loads the timer and the
// response reports its position, or a full-table rejection. A tick request,
// once accepted, rotates the whole row once through a single head evaluator,
// one cell per cycle unless a second fire meets a blocked response register,
// then releases the final fired response and closes the gaps left by removed
// timers before it returns to idle. Fired responses leave in table order; the
// last one of a tick carries last. A tick that fires nothing gives no
// response. Requests are taken only when the block is idle and the response
// register is free or draining.
`default_nettype none
`include "ordered_software_timer_table_core_assert.svh"
module ordered_software_timer_table_core #(
   parameter int SLOTS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  ostt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ostt_pkg::rsp_type rsp_data
);
   import ostt_pkg::*;

   localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_ROT     = 2'd1;
   localparam logic [1:0] ST_FLUSH   = 2'd2;
   localparam logic [1:0] ST_COMPACT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    keep_ff, keep_in;
   logic [DELTA_W-1:0]  delta_ff, delta_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [TAG_W-1:0]    pend_tag_ff, pend_tag_in;
   logic [POS_W-1:0]    pend_pos_ff, pend_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   entry_type           ent [SLOTS];
   logic [SLOTS-1:0]    hole_vec;
   logic [SLOTS-1:0]    misplaced_vec;
   logic [SLOTS-1:0]    valid_vec;
   entry_type           tail_entry;
   entry_type           eval_entry;
   entry_type           new_entry;
   logic                eval_fire;
   cell_ctrl_type       ctrl;

   logic                out_free;
   logic                req_accept;
   logic                table_full;
   logic                any_misplaced;
   logic                advance;
   logic [31:0]         count_wide;
   logic [31:0]         step_wide;

   // handshake
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall  = ~((state_ff == ST_IDLE) & out_free);
   assign req_accept = req_valid & ~req_stall;

   // table status from the hole chain
   assign table_full    = ~hole_vec[SLOTS-1];
   assign any_misplaced = |misplaced_vec;

   assign count_wide = 32'(count_ff);
   assign step_wide  = 32'(step_ff);

   // new timer built from the request
   always_comb begin
      new_entry         = '0;
      new_entry.valid   = 1'b1;
      new_entry.period  = req_data.period_ms;
      new_entry.elapsed = '0;
      new_entry.tag     = req_data.action_tag;
      new_entry.loops   = (req_data.repeat_mode == MODE_LOOP);
      if (req_data.repeat_mode == MODE_LOOP) begin
         new_entry.remaining = '0;
      end else if (req_data.repeat_mode == MODE_COUNTED && req_data.repeat_count != '0) begin
         new_entry.remaining = req_data.repeat_count;
      end else begin
         new_entry.remaining = COUNT_W'(1);
      end
   end

   // head evaluator sees cell 0
   ostt_eval u_eval (
      .head   (ent[0]),
      .delta  (delta_ff),
      .result (eval_entry),
      .fire   (eval_fire)
   );

   // rotation stalls only when a second fire meets a blocked response register
   assign advance = (state_ff == ST_ROT) & ~(eval_fire & pend_valid_ff & ~out_free);

   always_comb begin
      tail_entry = eval_entry;
      if (state_ff != ST_ROT) begin
         tail_entry.valid = 1'b0;
      end
   end

   assign ctrl.shift   = advance;
   assign ctrl.compact = (state_ff == ST_COMPACT) & any_misplaced;
   assign ctrl.add     = req_accept & (req_data.operation == OP_ADD) & ~table_full;

   // row of cells; cell 0 is the head, the last cell takes the evaluated entry
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      entry_type up_entry;
      logic      hole_below;
      if (i == SLOTS - 1) begin : g_top
         assign up_entry = tail_entry;
      end else begin : g_mid
         assign up_entry = ent[i+1];
      end
      if (i == 0) begin : g_first
         assign hole_below = 1'b0;
      end else begin : g_rest
         assign hole_below = hole_vec[i-1];
      end
      ostt_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .up_entry      (up_entry),
         .new_entry     (new_entry),
         .hole_below_in (hole_below),
         .entry_out     (ent[i]),
         .hole_out      (hole_vec[i]),
         .misplaced     (misplaced_vec[i])
      );
      assign valid_vec[i] = ent[i].valid;
   end

   // sequencer, pending fire and response register
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      keep_in       = keep_ff;
      delta_in      = delta_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.operation == OP_ADD) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.fired_tag = req_data.action_tag;
                  rsp_data_in.last      = 1'b1;
                  if (table_full) begin
                     rsp_data_in.kind     = KIND_FULL;
                     rsp_data_in.position = '0;
                  end else begin
                     rsp_data_in.kind     = KIND_ADDED;
                     rsp_data_in.position = count_wide[POS_W-1:0];
                     count_in             = count_ff + CNT_W'(1);
                  end
               end else begin
                  delta_in      = req_data.delta_ms;
                  step_in       = '0;
                  keep_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_ROT;
               end
            end
         end
         ST_ROT: begin
            if (advance) begin
               if (eval_entry.valid) begin
                  keep_in = keep_ff + CNT_W'(1);
               end
               if (eval_fire) begin
                  // release the older fire, hold the new one until we know it is not last
                  if (pend_valid_ff) begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.kind      = KIND_FIRED;
                     rsp_data_in.fired_tag = pend_tag_ff;
                     rsp_data_in.position  = pend_pos_ff;
                     rsp_data_in.last      = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_tag_in   = ent[0].tag;
                  pend_pos_in   = step_wide[POS_W-1:0];
               end
               if (step_ff == STEP_W'(SLOTS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.kind      = KIND_FIRED;
                  rsp_data_in.fired_tag = pend_tag_ff;
                  rsp_data_in.position  = pend_pos_ff;
                  rsp_data_in.last      = 1'b1;
               end
               pend_valid_in = 1'b0;
               count_in      = keep_ff;
               state_in      = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            if (!any_misplaced) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      step_ff     <= step_in;
      keep_ff     <= keep_in;
      delta_ff    <= delta_in;
      pend_tag_ff <= pend_tag_in;
      pend_pos_ff <= pend_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `OSTT_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff, "reset does not leave the block idle")
   `OSTT_ASSERT(a_idle_compact, clock, reset, (state_ff == ST_IDLE) |-> !any_misplaced, "table has a gap while idle")
   `OSTT_ASSERT(a_idle_count, clock, reset, (state_ff == ST_IDLE) |-> ($countones(valid_vec) == int'(count_ff)), "entry count disagrees with valid cells")
   `OSTT_ASSERT(a_hold_on_block, clock, reset, (state_ff == ST_ROT) && eval_fire && pend_valid_ff && !out_free |=> $stable(step_ff) && pend_valid_ff, "rotation moved while a fire was blocked")

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
   import ostt_pkg::*;

   localparam int SLOTS        = 16;
   localparam int RANDOM_ITEMS = 320;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 3 * SLOTS + 16;

   // repeat modes the package leaves unnamed
   localparam logic [MODE_W-1:0] MODE_ONCE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // expected-response tracker: mirrors the timer table and queues its responses
   class timer_table_tracker;
      bit [31:0] period    [SLOTS];
      bit [31:0] elapsed   [SLOTS];
      bit        loops     [SLOTS];
      bit [15:0] remaining [SLOTS];
      bit [7:0]  tag       [SLOTS];
      int        live;
      int        fault_count;
      rsp_type   due_responses[$];

      function new();
         live        = 0;
         fault_count = 0;
      endfunction

      function int loop_entries();
         int n;
         n = 0;
         for (int i = 0; i < live; i++)
            if (loops[i]) n++;
         return n;
      endfunction

      // append one expected response behind the ones already waiting
      function void queue_response(rsp_type r);
         due_responses = {due_responses, r};
      endfunction

      // work out the responses an accepted request causes
      function void note_request(req_type r);
         rsp_type   res;
         bit [32:0] sum;
         bit        keep;
         bit [7:0]  hit_tag [SLOTS];
         bit [3:0]  hit_pos [SLOTS];
         int        n;
         int        w;
         if (r.operation == OP_ADD) begin
            res.fired_tag = r.action_tag;
            res.last      = 1'b1;
            if (live >= SLOTS) begin
               res.kind     = KIND_FULL;
               res.position = '0;
            end else begin
               period[live]  = r.period_ms;
               elapsed[live] = '0;
               tag[live]     = r.action_tag;
               loops[live]   = (r.repeat_mode == MODE_LOOP);
               if (r.repeat_mode == MODE_LOOP)
                  remaining[live] = '0;
               else if (r.repeat_mode == MODE_COUNTED && r.repeat_count != 0)
                  remaining[live] = r.repeat_count;
               else
                  remaining[live] = 16'd1;
               res.kind     = KIND_ADDED;
               res.position = 4'(live);
               live++;
            end
            queue_response(res);
            return;
         end
         // tick: one ordered pass, survivors close up behind the write index
         n = 0;
         w = 0;
         for (int i = 0; i < live; i++) begin
            keep       = 1'b1;
            sum        = {1'b0, elapsed[i]} + {17'd0, r.delta_ms};
            elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (elapsed[i] >= period[i]) begin
               hit_tag[n] = tag[i];
               hit_pos[n] = 4'(i);
               n++;
               elapsed[i] = '0;
               if (!loops[i]) begin
                  if (remaining[i] <= 16'd1) begin
                     remaining[i] = '0;
                     keep         = 1'b0;
                  end else begin
                     remaining[i] = remaining[i] - 16'd1;
                  end
               end
            end
            if (keep) begin
               period[w]    = period[i];
               elapsed[w]   = elapsed[i];
               loops[w]     = loops[i];
               remaining[w] = remaining[i];
               tag[w]       = tag[i];
               w++;
            end
         end
         live = w;
         for (int j = 0; j < n; j++) begin
            res.kind      = KIND_FIRED;
            res.fired_tag = hit_tag[j];
            res.position  = hit_pos[j];
            res.last      = (j == n - 1);
            queue_response(res);
         end
      endfunction

      function void report_field(string name, int want, int got);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fault_count++;
      endfunction

      // compare an accepted response with the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual kind %0d tag %0d pos %0d",
                     $time, got.kind, got.fired_tag, got.position);
            fault_count++;
            return;
         end
         want = due_responses.pop_front();
         if (got.kind !== want.kind)           report_field("kind", want.kind, got.kind);
         if (got.fired_tag !== want.fired_tag) report_field("fired_tag", want.fired_tag,
                                                            got.fired_tag);
         if (got.position !== want.position)   report_field("position", want.position,
                                                            got.position);
         if (got.last !== want.last)           report_field("last", want.last, got.last);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   timer_table_tracker tracker;
   bit idle_on;
   int stall_left;
   int quiet_cycles;

   ordered_software_timer_table_core #(.SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // response side back-pressure in random bursts
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_data);
   end

   // progress watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // every field random; the helpers below overwrite what the operation uses
   function req_type noise_request();
      req_type r;
      r.operation    = 1'($urandom_range(0, 1));
      r.delta_ms     = 16'($urandom_range(0, 16'hFFFF));
      r.period_ms    = $urandom;
      r.repeat_mode  = 2'($urandom_range(0, 3));
      r.repeat_count = 16'($urandom_range(0, 16'hFFFF));
      r.action_tag   = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function req_type add_request(bit [31:0] p, bit [1:0] m, bit [15:0] c, bit [7:0] t);
      req_type r;
      r              = noise_request();
      r.operation    = OP_ADD;
      r.period_ms    = p;
      r.repeat_mode  = m;
      r.repeat_count = c;
      r.action_tag   = t;
      return r;
   endfunction

   function req_type tick_request(bit [15:0] d);
      req_type r;
      r           = noise_request();
      r.operation = OP_TICK;
      r.delta_ms  = d;
      return r;
   endfunction

   // random traffic; long-lived timers only while the table has room
   function req_type random_request();
      bit        roomy;
      bit        do_add;
      bit [31:0] p;
      bit [1:0]  m;
      bit [15:0] c;
      bit [15:0] d;
      int        pick;
      roomy  = tracker.live < 8;
      do_add = $urandom_range(0, 99) < (tracker.live < 12 ? 55 : 25);
      if (do_add) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)               p = '0;
         else if (pick == 1 && roomy) p = 32'hFFFF_FFFF;
         else if (pick == 2 && roomy) p = $urandom;
         else                         p = $urandom_range(1, 300);
         m = 2'($urandom_range(0, 3));
         if (m == MODE_LOOP && tracker.loop_entries() >= 4) m = MODE_COUNTED;
         pick = $urandom_range(0, 9);
         if (pick == 0)               c = '0;
         else if (pick == 1 && roomy) c = 16'hFFFF;
         else if (pick == 2 && roomy) c = 16'($urandom_range(0, 16'hFFFF));
         else                         c = 16'($urandom_range(1, 5));
         return add_request(p, m, c, 8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      d = '0;
      else if (pick == 1) d = 16'hFFFF;
      else if (pick == 2) d = 16'($urandom_range(0, 16'hFFFF));
      else                d = 16'($urandom_range(1, 120));
      return tick_request(d);
   endfunction

   // drive one request from a falling edge until it is taken; returns at a falling edge
   task send_request(req_type r);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(r);
      @(negedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idle_on   = 1'b0;
      tracker   = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // max-period timers age under full-scale ticks and stay in the table
      send_request(add_request(32'hFFFF_FFFF, MODE_COUNTED, 16'd1, 8'hA5));
      send_request(add_request(32'hFFFF_FFFF, MODE_ONCE, 16'd0, 8'h5A));
      send_request(tick_request(16'd1));
      for (int k = 0; k < 4; k++)
         send_request(tick_request(16'hFFFF));

      // full table: zero-period timers firing twice, then rejected adds
      for (int k = 0; k < SLOTS; k++)
         send_request(add_request('0, MODE_COUNTED, 16'd2,
                                  (k == 0) ? 8'h00 : (k == 1) ? 8'hFF :
                                  8'($urandom_range(0, 255))));
      send_request(add_request(32'd7, MODE_LOOP, 16'd0, 8'hC3));
      send_request(tick_request(16'd0));
      send_request(tick_request(16'd1));

      // modes, zero count, spare mode, zero period on a zero tick, max delta
      send_request(add_request('0, MODE_ONCE, 16'd0, 8'h01));
      send_request(add_request(32'hFFFF_FFFF, MODE_LOOP, 16'hFFFF, 8'h80));
      send_request(add_request(32'd5, MODE_COUNTED, 16'd0, 8'h11));
      send_request(add_request(32'd5, MODE_SPARE, 16'd9, 8'h22));
      send_request(add_request(32'd3, MODE_COUNTED, 16'd3, 8'h33));
      send_request(add_request(32'd10, MODE_LOOP, 16'd0, 8'h44));
      send_request(tick_request(16'd0));
      send_request(tick_request(16'd5));
      send_request(tick_request(16'hFFFF));
      send_request(tick_request(16'd3));

      // random part; quiet stretches, and none at all near the end
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         idle_on = (k < RANDOM_ITEMS * 5 / 6) && ((k / 45) % 4 != 3);
         send_request(random_request());
      end
      req_valid <= 1'b0;
      idle_on = 1'b0;

      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.fault_count == 0 && tracker.due_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
